// File: rtl/afb_pkg.sv
// Shared types and constants for the ack frame builder.
// Used by afb_front, afb_queue, afb_back and the top level.
package afb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_CODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_CODE = 1'd1;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // kind of work the back end has to carry out for one transaction
  typedef enum logic [1:0] {
    KIND_START,
    KIND_START_EMPTY,
    KIND_DATA,
    KIND_DATA_LAST
  } afb_kind_t;

  typedef struct packed {
    afb_kind_t   kind;
    logic [7:0]  func_code;
    logic [31:0] result_code;
    logic [15:0] data_length;
    logic [7:0]  data_byte;
    logic [7:0]  checksum;
  } afb_entry_t;

  // byte positions within a frame
  localparam logic [3:0] POS_HEAD_HI = 4'd0;
  localparam logic [3:0] POS_HEAD_LO = 4'd1;
  localparam logic [3:0] POS_FUNC    = 4'd2;
  localparam logic [3:0] POS_RES_3   = 4'd3;
  localparam logic [3:0] POS_RES_2   = 4'd4;
  localparam logic [3:0] POS_RES_1   = 4'd5;
  localparam logic [3:0] POS_RES_0   = 4'd6;
  localparam logic [3:0] POS_LEN_HI  = 4'd7;
  localparam logic [3:0] POS_LEN_LO  = 4'd8;
  localparam logic [3:0] POS_DATA    = 4'd9;
  localparam logic [3:0] POS_SUM     = 4'd10;
  localparam logic [3:0] POS_TAIL_HI = 4'd11;
  localparam logic [3:0] POS_TAIL_LO = 4'd12;

endpackage

// File: rtl/afb_front.sv
// Front end: accepts input transactions, tracks frame state and checksum,
// and pushes classified work entries. Depends on afb_pkg.
module afb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [7:0]          func_code,
  input  logic [31:0]         result_code,
  input  logic [15:0]         data_length,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  output logic                q_push,
  output afb_pkg::afb_entry_t q_entry
);

  logic        frame_open;
  logic [15:0] bytes_left;
  logic [7:0]  running_sum;
  logic        accept;
  logic [7:0]  hdr_sum;
  logic [7:0]  data_sum;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign hdr_sum = func_code + result_code[31:24] + result_code[23:16]
                 + result_code[15:8] + result_code[7:0]
                 + data_length[15:8] + data_length[7:0];
  assign data_sum = running_sum + data_byte;

  always_comb begin
    q_entry.func_code   = func_code;
    q_entry.result_code = result_code;
    q_entry.data_length = data_length;
    q_entry.data_byte   = data_byte;
    if (cmd == afb_pkg::CMD_START) begin
      q_entry.checksum = hdr_sum;
      q_entry.kind     = (data_length == 16'd0) ? afb_pkg::KIND_START_EMPTY
                                                : afb_pkg::KIND_START;
    end else begin
      q_entry.checksum = data_sum;
      q_entry.kind     = (bytes_left == 16'd1) ? afb_pkg::KIND_DATA_LAST
                                               : afb_pkg::KIND_DATA;
    end
  end

  // data with no frame open is taken and dropped
  assign q_push = accept && (cmd == afb_pkg::CMD_START || frame_open);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= 16'd0;
      running_sum <= 8'd0;
    end else if (accept) begin
      if (cmd == afb_pkg::CMD_START) begin
        running_sum <= hdr_sum;
        if (data_length == 16'd0) begin
          frame_open <= 1'b0;
          bytes_left <= 16'd0;
        end else begin
          frame_open <= 1'b1;
          bytes_left <= data_length;
        end
      end else if (frame_open) begin
        running_sum <= data_sum;
        if (bytes_left == 16'd1) begin
          frame_open <= 1'b0;
          bytes_left <= 16'd0;
        end else begin
          bytes_left <= bytes_left - 16'd1;
        end
      end
    end
  end

endmodule

// File: rtl/afb_queue.sv
// Short FIFO of work entries between front and back end.
// Depends on afb_pkg for the entry type.
module afb_queue #(
  parameter int DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afb_pkg::afb_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output afb_pkg::afb_entry_t pop_entry,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  afb_pkg::afb_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_FULL);
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/afb_back.sv
// Back end: takes work entries off the queue and serializes frame bytes,
// one per output transaction. Depends on afb_pkg.
module afb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         head_code,
  input  logic [15:0]         tail_code,
  input  logic                q_empty,
  input  afb_pkg::afb_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          frame_byte,
  output logic                frame_end
);

  afb_pkg::afb_entry_t cur;
  logic                cur_valid;
  logic [3:0]          pos;
  logic [3:0]          last_pos;
  logic [3:0]          pos_next;
  logic                finishing;
  logic                load;

  always_comb begin
    case (cur.kind)
      afb_pkg::KIND_START: last_pos = afb_pkg::POS_LEN_LO;
      afb_pkg::KIND_DATA:  last_pos = afb_pkg::POS_DATA;
      default:             last_pos = afb_pkg::POS_TAIL_LO;
    endcase
  end

  // an empty frame goes straight from the length to the checksum
  assign pos_next = (pos == afb_pkg::POS_LEN_LO && cur.kind == afb_pkg::KIND_START_EMPTY)
                  ? afb_pkg::POS_SUM : pos + 4'd1;

  assign finishing = cur_valid && out_ready && (pos == last_pos);
  assign load      = !cur_valid || finishing;
  assign q_pop     = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= afb_pkg::POS_HEAD_HI;
    end else if (load) begin
      cur_valid <= !q_empty;
      if (!q_empty) begin
        cur <= q_entry;
        pos <= (q_entry.kind == afb_pkg::KIND_DATA || q_entry.kind == afb_pkg::KIND_DATA_LAST)
             ? afb_pkg::POS_DATA : afb_pkg::POS_HEAD_HI;
      end
    end else if (cur_valid && out_ready) begin
      pos <= pos_next;
    end
  end

  assign out_valid = cur_valid;
  assign frame_end = (pos == afb_pkg::POS_TAIL_LO);

  always_comb begin
    case (pos)
      afb_pkg::POS_HEAD_HI: frame_byte = head_code[15:8];
      afb_pkg::POS_HEAD_LO: frame_byte = head_code[7:0];
      afb_pkg::POS_FUNC:    frame_byte = cur.func_code;
      afb_pkg::POS_RES_3:   frame_byte = cur.result_code[31:24];
      afb_pkg::POS_RES_2:   frame_byte = cur.result_code[23:16];
      afb_pkg::POS_RES_1:   frame_byte = cur.result_code[15:8];
      afb_pkg::POS_RES_0:   frame_byte = cur.result_code[7:0];
      afb_pkg::POS_LEN_HI:  frame_byte = cur.data_length[15:8];
      afb_pkg::POS_LEN_LO:  frame_byte = cur.data_length[7:0];
      afb_pkg::POS_DATA:    frame_byte = cur.data_byte;
      afb_pkg::POS_SUM:     frame_byte = cur.checksum;
      afb_pkg::POS_TAIL_HI: frame_byte = tail_code[15:8];
      afb_pkg::POS_TAIL_LO: frame_byte = tail_code[7:0];
      default:              frame_byte = 8'd0;
    endcase
  end

endmodule

// File: rtl/ack_frame_builder_sum_check_core.sv
// Top level of the ack frame builder with additive checksum.
// Depends on afb_pkg, afb_front, afb_queue and afb_back.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | cmd, func_code, result_code, data_length, data_byte
//  out     | out_valid/out_ready | frame_byte, frame_end
//  cfg     | cfg_we              | cfg_index, cfg_data (head_code, tail_code)
//
// The front end takes one input transaction per cycle while the queue has room.
// The back end sends one frame byte per cycle while out_ready is high and entries are
// available: a start yields 9 bytes (12 for an empty frame), a data byte 1 (4 for the
// last one). Output bandwidth is the limit; the queue lets input run ahead by its depth.
// Synchronous reset clears frame state, queue pointers and output valid.
module ack_frame_builder_sum_check_core #(
  parameter int QUEUE_DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [7:0]                      func_code,
  input  logic [31:0]                     result_code,
  input  logic [15:0]                     data_length,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      frame_byte,
  output logic                            frame_end,
  input  logic                            cfg_we,
  input  logic [afb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [afb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0]         head_code;
  logic [15:0]         tail_code;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  afb_pkg::afb_entry_t push_entry;
  afb_pkg::afb_entry_t pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_code <= 16'd0;
      tail_code <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        afb_pkg::REG_HEAD_CODE: head_code <= cfg_data;
        afb_pkg::REG_TAIL_CODE: tail_code <= cfg_data;
        default: ;
      endcase
    end
  end

  afb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .func_code   (func_code),
    .result_code (result_code),
    .data_length (data_length),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  afb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  afb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_code  (head_code),
    .tail_code  (tail_code),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

endmodule

// File: bench/afb_tb_pkg.sv
`timescale 1ns / 100ps
// Command codes shared by the frame builder bench stimulus and checker.
// No dependencies.
package afb_tb_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

endpackage

// File: bench/reply_frame_checker.sv
`timescale 1ns / 100ps
// Watches the input, output and config ports of the ack frame builder, predicts
// the reply byte stream and compares it. Depends on afb_pkg and afb_tb_pkg.
module reply_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            cmd,
  input  logic [7:0]                      func_code,
  input  logic [31:0]                     result_code,
  input  logic [15:0]                     data_length,
  input  logic [7:0]                      data_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      frame_byte,
  input  logic                            frame_end,
  input  logic                            cfg_we,
  input  logic [afb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [afb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     bytes_due
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } reply_byte_t;

  reply_byte_t frame_bytes_due[$];

  logic [15:0] head_word;
  logic [15:0] tail_word;
  logic [15:0] data_owed;
  logic [7:0]  sum_acc;
  logic        in_frame;
  int unsigned fault_count = 0;

  assign mismatches = fault_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last, input logic summed);
    reply_byte_t rb;
    rb.value = b;
    rb.last  = last;
    frame_bytes_due.push_back(rb);
    if (summed) sum_acc = sum_acc + b;
  endtask

  task automatic close_frame;
    queue_byte(sum_acc, 1'b0, 1'b0);
    queue_byte(tail_word[15:8], 1'b0, 1'b0);
    queue_byte(tail_word[7:0], 1'b1, 1'b0);
    in_frame  = 1'b0;
    data_owed = '0;
  endtask

  task automatic predict_frame_bytes(input logic c, input logic [7:0] fc,
                                     input logic [31:0] rc, input logic [15:0] len,
                                     input logic [7:0] db);
    if (c == afb_tb_pkg::CMD_START) begin
      // a start drops any unfinished frame without trailer
      sum_acc = '0;
      queue_byte(head_word[15:8], 1'b0, 1'b0);
      queue_byte(head_word[7:0], 1'b0, 1'b0);
      queue_byte(fc, 1'b0, 1'b1);
      queue_byte(rc[31:24], 1'b0, 1'b1);
      queue_byte(rc[23:16], 1'b0, 1'b1);
      queue_byte(rc[15:8], 1'b0, 1'b1);
      queue_byte(rc[7:0], 1'b0, 1'b1);
      queue_byte(len[15:8], 1'b0, 1'b1);
      queue_byte(len[7:0], 1'b0, 1'b1);
      if (len == 16'd0) begin
        close_frame();
      end else begin
        data_owed = len;
        in_frame  = 1'b1;
      end
    end else if (in_frame) begin
      queue_byte(db, 1'b0, 1'b1);
      data_owed = data_owed - 16'd1;
      if (data_owed == 16'd0) close_frame();
    end
  endtask

  always @(posedge clk) begin
    reply_byte_t due;
    if (rst) begin
      frame_bytes_due.delete();
      head_word = '0;
      tail_word = '0;
      data_owed = '0;
      sum_acc   = '0;
      in_frame  = 1'b0;
      bytes_due <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == afb_pkg::REG_HEAD_CODE) head_word = cfg_data;
        else if (cfg_index == afb_pkg::REG_TAIL_CODE) tail_word = cfg_data;
      end
      if (in_valid && in_ready)
        predict_frame_bytes(cmd, func_code, result_code, data_length, data_byte);
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end %b", frame_byte, frame_end));
        end else begin
          due = frame_bytes_due.pop_front();
          if (frame_byte !== due.value)
            report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte, due.value));
          if (frame_end !== due.last)
            report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
                                      frame_end, due.last, due.value));
        end
      end
      bytes_due <= frame_bytes_due.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the ack frame builder bench: clock, reset, stimulus, output stalls,
// watchdog and verdict. Uses afb_pkg, afb_tb_pkg, the core, reply_frame_checker.
module tb_top;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 190;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            in_valid    = 1'b0;
  logic                            cmd         = afb_tb_pkg::CMD_START;
  logic [7:0]                      func_code   = '0;
  logic [31:0]                     result_code = '0;
  logic [15:0]                     data_length = '0;
  logic [7:0]                      data_byte   = '0;
  logic                            out_ready   = 1'b0;
  logic                            cfg_we      = 1'b0;
  logic [afb_pkg::CFG_INDEX_W-1:0] cfg_index   = afb_pkg::REG_HEAD_CODE;
  logic [afb_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                            in_ready;
  logic                            out_valid;
  logic [7:0]                      frame_byte;
  logic                            frame_end;
  int unsigned                     mismatches;
  int unsigned                     bytes_due;

  int          burst_left   = 0;
  int          counted      = 0;
  logic        frame_live   = 1'b0;
  int          data_left    = 0;
  int unsigned stall_left   = 0;
  logic [8:0]  pace         = '0;
  int unsigned quiet_cycles = 0;

  ack_frame_builder_sum_check_core dut (.*);

  reply_frame_checker frame_check (.*);

  always #5 clk = ~clk;

  // receiver: stall behavior follows the top two bits of pace, one mode never stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      pace       <= '0;
    end else begin
      pace <= pace + 9'd1;
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        case (pace[8:7])
          2'd0: ;
          2'd1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 6);
          2'd2: if ($urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 2);
          default: if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(3, 6);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] fc, input logic [31:0] rc,
                           input logic [15:0] len, input logic [7:0] db);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid    <= 1'b1;
    cmd         <= c;
    func_code   <= fc;
    result_code <= rc;
    data_length <= len;
    data_byte   <= db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_start(input logic [7:0] fc, input logic [31:0] rc, input logic [15:0] len);
    send_item(afb_tb_pkg::CMD_START, fc, rc, len, 8'($urandom));
    counted++;
    frame_live = (len != 16'd0);
    data_left  = len;
  endtask

  // unused header fields carry noise; data with no frame open is not counted
  task automatic send_data(input logic [7:0] db);
    send_item(afb_tb_pkg::CMD_DATA, 8'($urandom), $urandom, 16'($urandom), db);
    if (frame_live) begin
      counted++;
      data_left--;
      if (data_left == 0) frame_live = 1'b0;
    end
  endtask

  task automatic wait_drained;
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(input logic [15:0] head, input logic [15:0] tail);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= afb_pkg::REG_HEAD_CODE;
    cfg_data  <= head;
    @(posedge clk);
    cfg_index <= afb_pkg::REG_TAIL_CODE;
    cfg_data  <= tail;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pick;
    int len;
    int sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset codes: stray data, empty frames at both extremes
    send_data(8'hFF);
    send_start(8'h00, 32'h0000_0000, 16'h0000);
    send_start(8'hFF, 32'hFFFF_FFFF, 16'h0000);

    set_codes(16'hFFFF, 16'h0000);
    send_start(8'h5A, 32'h1234_5678, 16'h0001);
    send_data(8'hFF);
    send_start(8'h01, 32'h8000_0001, 16'h0003);
    send_data(8'h00);
    // restart while a frame is still open
    send_start(8'hA5, 32'h7FFF_FFFE, 16'h0002);
    send_data(8'h80);
    send_data(8'h7F);
    send_data(8'h55);

    set_codes(16'h0000, 16'hFFFF);
    send_start(8'hC3, 32'hDEAD_BEEF, 16'hFFFF);
    send_data(8'h01);
    send_data(8'hFE);
    send_start(8'h3C, 32'h00FF_00FF, 16'h8000);
    send_data(8'hAA);
    send_start(8'h00, 32'h0000_0000, 16'h0001);
    send_data(8'h00);

    set_codes(16'hA55A, 16'h5AA5);
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        send_start(8'($urandom), $urandom, 16'(len));
        // now and then the frame is cut short and abandoned by the next start
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        repeat (sent) send_data(8'($urandom));
      end else if (pick < 77) begin
        send_start(8'($urandom), $urandom, 16'($urandom));
        repeat ($urandom_range(0, 3)) send_data(8'($urandom));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 3)) send_data(8'($urandom));
      end else if (pick < 95) begin
        case ($urandom_range(0, 3))
          0: set_codes(16'h0000, 16'hFFFF);
          1: set_codes(16'hFFFF, 16'h0000);
          default: set_codes(16'($urandom), 16'($urandom));
        endcase
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0 && bytes_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
